// File: rtl/pmoe_pkg.sv
// ----------------------------------------------------------------------------
// pmoe_pkg
// Shared types and constants of the point moments / orientation / extent block.
// ----------------------------------------------------------------------------
package pmoe_pkg;

  // Cloud and number formats
  localparam int MAX_POINTS      = 4096;
  localparam int CNT_W           = 13;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int COORD_W         = 16;
  localparam int WXY_W           = 26;   // weighted coordinate
  localparam int PROD_W          = 50;   // product of two weighted coordinates
  localparam int SUM1_W          = 41;
  localparam int SUM2_W          = 61;
  localparam int SUMXY_W         = 62;
  localparam int ORIENT_W        = 15;
  localparam int EXT_W           = 26;
  localparam logic [EXT_W-1:0] EXTENT_MAX = EXT_W'(58118000);

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One weighted point with its products
  typedef struct packed {
    logic signed [WXY_W-1:0]  wx;
    logic signed [WXY_W-1:0]  wy;
    logic        [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] xy;
    logic        [PROD_W-1:0] yy;
    logic                     last;
  } q_entry_t;

  // One finished result
  typedef struct packed {
    logic        [CNT_W-1:0]    count;
    logic signed [SUM1_W-1:0]   sx;
    logic signed [SUM1_W-1:0]   sy;
    logic        [SUM2_W-1:0]   sxx;
    logic signed [SUMXY_W-1:0]  sxy;
    logic        [SUM2_W-1:0]   syy;
    logic signed [ORIENT_W-1:0] orient;
    logic        [EXT_W-1:0]    ext_major;
    logic        [EXT_W-1:0]    ext_minor;
    logic                       empty;
    logic                       overflow;
  } res_t;

endpackage

// File: rtl/point_moments_orientation_extent_top.sv
// ----------------------------------------------------------------------------
// point_moments_orientation_extent_top
// Streams 2D points of a cloud and reports moments, orientation and extents.
// ----------------------------------------------------------------------------
// Points are taken one per cycle: a two-stage front (height weighting, then
// products) feeds a four-entry queue, and the back adds one point per cycle
// into the moment sums while it is not finishing a cloud. On the point marked
// tlast the back runs a sequencer (normalize shifts, CORDIC steps, squaring,
// three bitwise square roots and two bitwise divisions by the count); points
// keep entering until the queue fills, then in_tready drops until the result
// is loaded into the output register.
module point_moments_orientation_extent_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,     // weight_by_height
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,        // point_x, point_y, point_z
  input  logic         in_tlast,        // last_point
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_count, sum_x, sum_y, sum_xx, sum_xy, sum_yy, orientation,
  // extent_major, extent_minor, zero fill
  output logic [351:0] out_tdata,
  output logic [1:0]   out_tuser        // empty_cloud, count_overflow
);
  import pmoe_pkg::*;

  logic     weight_r;
  logic     push, q_full, pop, q_not_empty;
  q_entry_t push_data, pop_data;
  res_t     res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) weight_r <= 1'b0;
    else if (cfg_wr_en) weight_r <= cfg_wr_data;
  end

  pmoe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .weight_en (weight_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x      ($signed(in_tdata[15:0])),
    .in_y      ($signed(in_tdata[31:16])),
    .in_z      ($signed(in_tdata[47:32])),
    .in_last   (in_tlast),
    .push      (push),
    .q_full    (q_full),
    .push_data (push_data)
  );

  pmoe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  pmoe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (res)
  );

  // Pack the result
  assign out_tdata = {6'b0, res.ext_minor, res.ext_major, res.orient, res.syy, res.sxy,
                      res.sxx, res.sy, res.sx, res.count};
  assign out_tuser = {res.overflow, res.empty};

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[345:279] == '0)
    else $error("empty cloud with nonzero angle or extent");
  a_ext_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[319:294] <= EXTENT_MAX && out_tdata[345:320] <= EXTENT_MAX)
    else $error("extent above saturation limit");
  a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[345:320] <= out_tdata[319:294])
    else $error("minor extent larger than major extent");
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:0] <= 13'(MAX_POINTS))
    else $error("point count beyond maximum");
`endif

endmodule

// File: rtl/pmoe_front.sv
// ----------------------------------------------------------------------------
// pmoe_front
// Two-stage input pipeline: height weighting, then the three products.
// ----------------------------------------------------------------------------
module pmoe_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               weight_en,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pmoe_pkg::COORD_W-1:0] in_x,
  input  logic signed [pmoe_pkg::COORD_W-1:0] in_y,
  input  logic signed [pmoe_pkg::COORD_W-1:0] in_z,
  input  logic                               in_last,
  output logic                               push,
  input  logic                               q_full,
  output pmoe_pkg::q_entry_t                 push_data
);
  import pmoe_pkg::*;

  logic                     s1_v_r;
  logic signed [31:0]       s1_x_r, s1_y_r;
  logic                     s1_last_r;
  logic                     s2_v_r;
  q_entry_t                 s2_r;
  logic                     s1_free, s2_free;
  logic signed [31:0]       sh_x, sh_y;
  logic signed [WXY_W-1:0]  wx, wy;
  logic signed [PROD_W-1:0] xx_c, yy_c;

  // Stall control: each stage frees up when the next one takes its item
  assign s2_free  = !s2_v_r || !q_full;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign push     = s2_v_r && !q_full;
  assign push_data = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= in_valid;
      if (s2_free) s2_v_r <= s1_v_r;
    end
  end

  // Stage 1: height product or plain coordinate
  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      if (weight_en) begin
        s1_x_r <= in_x * in_z;
        s1_y_r <= in_y * in_z;
      end else begin
        s1_x_r <= 32'(in_x);
        s1_y_r <= 32'(in_y);
      end
      s1_last_r <= in_last;
    end
  end

  // Stage 2: scale back, then square and cross products
  assign sh_x = weight_en ? (s1_x_r >>> 6) : s1_x_r;
  assign sh_y = weight_en ? (s1_y_r >>> 6) : s1_y_r;
  assign wx   = $signed(sh_x[WXY_W-1:0]);
  assign wy   = $signed(sh_y[WXY_W-1:0]);
  assign xx_c = wx * wx;
  assign yy_c = wy * wy;

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      s2_r.wx   <= wx;
      s2_r.wy   <= wy;
      s2_r.xx   <= xx_c;
      s2_r.xy   <= wx * wy;
      s2_r.yy   <= yy_c;
      s2_r.last <= s1_last_r;
    end
  end

endmodule

// File: rtl/pmoe_queue.sv
// ----------------------------------------------------------------------------
// pmoe_queue
// Short FIFO of weighted points between the front and the back.
// ----------------------------------------------------------------------------
module pmoe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pmoe_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output pmoe_pkg::q_entry_t pop_data
);
  import pmoe_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Write side
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: rtl/pmoe_back.sv
// ----------------------------------------------------------------------------
// pmoe_back
// Moment accumulators and the end-of-cloud sequencer: normalize, CORDIC angle,
// eigenvalue root, extent division and root, result register.
// ----------------------------------------------------------------------------
module pmoe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  pmoe_pkg::q_entry_t q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pmoe_pkg::res_t     out_data
);
  import pmoe_pkg::*;

  localparam int AB_W   = 63;                 // |2*sxy| and |sxx-syy|
  localparam int C_W    = 34;                 // CORDIC vector
  localparam int Z_W    = 20;                 // Q16 angle
  localparam int CSTEPS = 17;
  localparam int DIV_W  = 67;                 // 12 * moment
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = Z_W'(102944);
  localparam logic signed [Z_W-1:0] PI_Q16      = Z_W'(205887);
  localparam logic signed [Z_W-1:0] ROUND_HALF  = Z_W'(1 << (16 - ANGLE_FRAC_BITS));
  localparam int ORIENT_SH = 17 - ANGLE_FRAC_BITS;

  typedef enum logic [10:0] {
    ST_ACC   = 11'b00000000001,
    ST_PREP  = 11'b00000000010,
    ST_NORM  = 11'b00000000100,
    ST_CINIT = 11'b00000001000,
    ST_CORD  = 11'b00000010000,
    ST_SQ1   = 11'b00000100000,
    ST_SQ2   = 11'b00001000000,
    ST_SQ3   = 11'b00010000000,
    ST_SQRT  = 11'b00100000000,
    ST_DIV   = 11'b01000000000,
    ST_DINIT = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_RAD = 3'b001,
    PH_MAJ = 3'b010,
    PH_MIN = 3'b100
  } phase_t;

  logic st_done_r;
  state_t state_r;
  phase_t phase_r;

  // Accumulators
  logic        [CNT_W-1:0]   cnt_r;
  logic signed [SUM1_W-1:0]  sx_r, sy_r;
  logic        [SUM2_W-1:0]  sxx_r, syy_r;
  logic signed [SUMXY_W-1:0] sxy_r;
  logic                      ovf_r;

  // Finishing datapath
  logic [AB_W-1:0]           ua_r, ud_r;
  logic                      a_neg_r, d_neg_r;
  logic [SUMXY_W-1:0]        ssum_r;
  logic [5:0]                s_r;
  logic signed [C_W-1:0]     cx_r, cy_r;
  logic signed [Z_W-1:0]     cz_r;
  logic [4:0]                it_r;
  logic signed [ORIENT_W-1:0] orient_r;
  logic [59:0]               prod_r, sqa_r;
  logic [63:0]               rt_v_r, rt_res_r, rt_bit_r;
  logic [63:0]               maj_r, mnr_r;
  logic [DIV_W-1:0]          dv_q_r;
  logic [CNT_W-1:0]          dv_rem_r;
  logic [6:0]                dv_cnt_r;
  logic [EXT_W-1:0]          ext_maj_r, ext_min_r;
  logic                      out_v_r;
  res_t                      res_r;

  // Combinational helpers
  logic signed [AB_W-1:0]    a_c;
  logic signed [SUMXY_W-1:0] d_c;
  logic signed [C_W-1:0]     x0_c, y0_c;
  logic [63:0]               rt_t_c, r_c;
  logic [64:0]               sr_sum_c;
  logic [CNT_W:0]            dv_sh_c;
  logic [63:0]               dv_m_c;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:    atan_q16 = Z_W'(51472);
      5'd1:    atan_q16 = Z_W'(30386);
      5'd2:    atan_q16 = Z_W'(16055);
      5'd3:    atan_q16 = Z_W'(8150);
      5'd4:    atan_q16 = Z_W'(4091);
      5'd5:    atan_q16 = Z_W'(2047);
      5'd6:    atan_q16 = Z_W'(1024);
      5'd7:    atan_q16 = Z_W'(512);
      5'd8:    atan_q16 = Z_W'(256);
      5'd9:    atan_q16 = Z_W'(128);
      5'd10:   atan_q16 = Z_W'(64);
      5'd11:   atan_q16 = Z_W'(32);
      5'd12:   atan_q16 = Z_W'(16);
      5'd13:   atan_q16 = Z_W'(8);
      5'd14:   atan_q16 = Z_W'(4);
      5'd15:   atan_q16 = Z_W'(2);
      default: atan_q16 = Z_W'(1);
    endcase
  endfunction

  // Clamp the doubled angle, halve it and round to the output fraction
  function automatic logic signed [ORIENT_W-1:0] orient_of(input logic signed [Z_W-1:0] z);
    logic signed [Z_W-1:0] zc;
    logic signed [Z_W-1:0] zr;
    zc = z;
    if (z > PI_Q16)  zc = PI_Q16;
    if (z < -PI_Q16) zc = -PI_Q16;
    zr = (zc + ROUND_HALF) >>> ORIENT_SH;
    orient_of = zr[ORIENT_W-1:0];
  endfunction

  function automatic logic [EXT_W-1:0] sat_ext(input logic [63:0] v);
    sat_ext = (v > 64'(EXTENT_MAX)) ? EXTENT_MAX : v[EXT_W-1:0];
  endfunction

  assign pop       = (state_r == ST_ACC) && !st_done_r && q_not_empty;
  assign out_valid = out_v_r;
  assign out_data  = res_r;

  assign a_c      = {sxy_r, 1'b0};
  assign d_c      = $signed(SUMXY_W'(sxx_r)) - $signed(SUMXY_W'(syy_r));
  assign x0_c     = d_neg_r ? -$signed(C_W'(ud_r[29:0])) : $signed(C_W'(ud_r[29:0]));
  assign y0_c     = a_neg_r ? -$signed(C_W'(ua_r[29:0])) : $signed(C_W'(ua_r[29:0]));
  assign rt_t_c   = rt_res_r + rt_bit_r;
  assign r_c      = rt_res_r << s_r;
  assign sr_sum_c = 65'(ssum_r) + 65'(r_c);
  assign dv_sh_c  = {dv_rem_r, dv_q_r[DIV_W-1]};
  assign dv_m_c   = (phase_r == PH_MAJ) ? maj_r : mnr_r;

  // Control: sequencer state, output valid, accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_ACC;
      st_done_r <= 1'b0;
      phase_r   <= PH_RAD;
      out_v_r   <= 1'b0;
      cnt_r     <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      sxx_r     <= '0;
      sxy_r     <= '0;
      syy_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      // Load the output register, or free it once its transfer completes
      if (state_r == ST_ACC && st_done_r && (!out_v_r || out_ready)) out_v_r <= 1'b1;
      else if (out_v_r && out_ready) out_v_r <= 1'b0;
      case (state_r)
        ST_ACC: begin
          if (st_done_r) begin
            // Hand over the result and clear for the next cloud
            if (!out_v_r || out_ready) begin
              st_done_r <= 1'b0;
              cnt_r     <= '0;
              sx_r      <= '0;
              sy_r      <= '0;
              sxx_r     <= '0;
              sxy_r     <= '0;
              syy_r     <= '0;
              ovf_r     <= 1'b0;
            end
          end else if (q_not_empty) begin
            if (cnt_r == CNT_W'(MAX_POINTS)) begin
              ovf_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              sx_r  <= sx_r + SUM1_W'(q_data.wx);
              sy_r  <= sy_r + SUM1_W'(q_data.wy);
              sxx_r <= sxx_r + SUM2_W'(q_data.xx);
              sxy_r <= sxy_r + SUMXY_W'(q_data.xy);
              syy_r <= syy_r + SUM2_W'(q_data.yy);
            end
            if (q_data.last) state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (cnt_r == '0) begin
            state_r   <= ST_ACC;
            st_done_r <= 1'b1;
          end else begin
            state_r <= ST_NORM;
          end
        end
        ST_NORM: begin
          if ((|ua_r[AB_W-1:30]) == 1'b0 && (|ud_r[AB_W-1:30]) == 1'b0) state_r <= ST_CINIT;
        end
        ST_CINIT: begin
          if ((x0_c == '0 && y0_c == '0) || (y0_c == '0 && x0_c < 0)) state_r <= ST_SQ1;
          else state_r <= ST_CORD;
        end
        ST_CORD: begin
          if (cy_r == '0 || it_r == 5'(CSTEPS)) state_r <= ST_SQ1;
        end
        ST_SQ1: state_r <= ST_SQ2;
        ST_SQ2: state_r <= ST_SQ3;
        ST_SQ3: begin
          state_r <= ST_SQRT;
          phase_r <= PH_RAD;
        end
        ST_SQRT: begin
          if (rt_bit_r == '0) begin
            case (phase_r)
              PH_RAD: begin
                phase_r <= PH_MAJ;
                state_r <= ST_DINIT;
              end
              PH_MAJ: begin
                phase_r <= PH_MIN;
                state_r <= ST_DINIT;
              end
              default: begin
                state_r   <= ST_ACC;
                st_done_r <= 1'b1;
              end
            endcase
          end
        end
        ST_DINIT: state_r <= ST_DIV;
        ST_DIV: begin
          if (dv_cnt_r == 7'(DIV_W)) state_r <= ST_SQRT;
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

  // Datapath registers of the finishing sequence
  always_ff @(posedge clk) begin
    case (state_r)
      ST_ACC: begin
        if (st_done_r && (!out_v_r || out_ready)) begin
          res_r.count     <= cnt_r;
          res_r.sx        <= sx_r;
          res_r.sy        <= sy_r;
          res_r.sxx       <= sxx_r;
          res_r.sxy       <= sxy_r;
          res_r.syy       <= syy_r;
          res_r.orient    <= orient_r;
          res_r.ext_major <= ext_maj_r;
          res_r.ext_minor <= ext_min_r;
          res_r.empty     <= (cnt_r == '0);
          res_r.overflow  <= ovf_r;
        end
      end
      ST_PREP: begin
        // Magnitudes of 2*sxy and sxx-syy, trace, and empty-cloud zeros
        ua_r      <= a_c[AB_W-1] ? AB_W'(-a_c) : AB_W'(a_c);
        ud_r      <= d_c[SUMXY_W-1] ? AB_W'(-d_c) : AB_W'(d_c);
        a_neg_r   <= a_c[AB_W-1];
        d_neg_r   <= d_c[SUMXY_W-1];
        ssum_r    <= SUMXY_W'(sxx_r) + SUMXY_W'(syy_r);
        s_r       <= '0;
        orient_r  <= '0;
        ext_maj_r <= '0;
        ext_min_r <= '0;
      end
      ST_NORM: begin
        // Drop one bit until both magnitudes fit in 30 bits
        if ((|ua_r[AB_W-1:30]) || (|ud_r[AB_W-1:30])) begin
          ua_r <= ua_r >> 1;
          ud_r <= ud_r >> 1;
          s_r  <= s_r + 1'b1;
        end
      end
      ST_CINIT: begin
        it_r <= '0;
        if (x0_c == '0 && y0_c == '0) begin
          orient_r <= orient_of('0);
        end else if (y0_c == '0 && x0_c < 0) begin
          orient_r <= orient_of(PI_Q16);
        end else if (x0_c <= 0) begin
          // Pre-rotate by a quarter turn into the right half plane
          if (y0_c > 0) begin
            cx_r <= y0_c;
            cy_r <= -x0_c;
            cz_r <= HALF_PI_Q16;
          end else begin
            cx_r <= -y0_c;
            cy_r <= x0_c;
            cz_r <= -HALF_PI_Q16;
          end
        end else begin
          cx_r <= x0_c;
          cy_r <= y0_c;
          cz_r <= '0;
        end
      end
      ST_CORD: begin
        if (cy_r == '0 || it_r == 5'(CSTEPS)) begin
          orient_r <= orient_of(cz_r);
        end else begin
          // One vectoring micro-rotation
          if (cy_r > 0) begin
            cx_r <= cx_r + (cy_r >>> it_r);
            cy_r <= cy_r - (cx_r >>> it_r);
            cz_r <= cz_r + atan_q16(it_r);
          end else begin
            cx_r <= cx_r - (cy_r >>> it_r);
            cy_r <= cy_r + (cx_r >>> it_r);
            cz_r <= cz_r - atan_q16(it_r);
          end
          it_r <= it_r + 1'b1;
        end
      end
      ST_SQ1: prod_r <= ud_r[29:0] * ud_r[29:0];
      ST_SQ2: begin
        sqa_r  <= prod_r;
        prod_r <= ua_r[29:0] * ua_r[29:0];
      end
      ST_SQ3: begin
        rt_v_r   <= 64'(sqa_r) + 64'(prod_r);
        rt_res_r <= '0;
        rt_bit_r <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: begin
        if (rt_bit_r != '0) begin
          // One result bit of the integer square root
          if (rt_v_r >= rt_t_c) begin
            rt_v_r   <= rt_v_r - rt_t_c;
            rt_res_r <= (rt_res_r >> 1) + rt_bit_r;
          end else begin
            rt_res_r <= rt_res_r >> 1;
          end
          rt_bit_r <= rt_bit_r >> 2;
        end else begin
          case (phase_r)
            PH_RAD: begin
              maj_r <= sr_sum_c[64:1];
              mnr_r <= (r_c > 64'(ssum_r)) ? '0 : ((64'(ssum_r) - r_c) >> 1);
            end
            PH_MAJ:  ext_maj_r <= sat_ext(rt_res_r);
            default: ext_min_r <= sat_ext(rt_res_r);
          endcase
        end
      end
      ST_DINIT: begin
        dv_q_r   <= (DIV_W'(dv_m_c) << 3) + (DIV_W'(dv_m_c) << 2);
        dv_rem_r <= '0;
        dv_cnt_r <= '0;
      end
      ST_DIV: begin
        if (dv_cnt_r == 7'(DIV_W)) begin
          rt_v_r   <= dv_q_r[63:0];
          rt_res_r <= '0;
          rt_bit_r <= 64'h4000_0000_0000_0000;
        end else begin
          // Restoring division by the point count, one quotient bit
          if (dv_sh_c >= {1'b0, cnt_r}) begin
            dv_rem_r <= CNT_W'(dv_sh_c - {1'b0, cnt_r});
            dv_q_r   <= {dv_q_r[DIV_W-2:0], 1'b1};
          end else begin
            dv_rem_r <= dv_sh_c[CNT_W-1:0];
            dv_q_r   <= {dv_q_r[DIV_W-2:0], 1'b0};
          end
          dv_cnt_r <= dv_cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: verif/tb_point_moments_orientation_extent_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_moments_orientation_extent_top
// Streams point clouds into the block (plain, height-weighted and degenerate
// clouds) and checks every result field against a cycle-free predictor of the
// moments, CORDIC orientation and square-root extents.
// ----------------------------------------------------------------------------
module tb_point_moments_orientation_extent_top;
  import pmoe_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     DRAIN_CYCLES = 400;

  // Moment accumulation and result prediction for one cloud at a time
  class cloud_scoreboard;
    bit        weighted;
    longint    cnt, sx, sy, sxy;
    longint unsigned sxx, syy;
    bit        ovf;
    res_t      results_due[$];
    int        errors;

    function void clear_sums();
      cnt = 0; sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0; ovf = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Q16 angle of (x, y) by vectoring rotation
    function longint angle_q16(longint x, longint y);
      longint atan_tab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                256, 128, 64, 32, 16, 8, 4, 2, 1};
      longint z, t, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (y == 0 && x < 0) return 205887;
      if (x <= 0) begin
        t = x;
        if (y > 0) begin
          x = y; y = -t; z = 102944;
        end else begin
          x = -y; y = t; z = -102944;
        end
      end
      for (int i = 0; i < 17; i++) begin
        if (y == 0) break;
        if (y > 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
        end
        x = nx; y = ny;
      end
      if (z > 205887) z = 205887;
      if (z < -205887) z = -205887;
      return z;
    endfunction

    function longint unsigned extent(longint unsigned m, longint unsigned n);
      longint unsigned e;
      e = isqrt(64'd12 * (m / n) + (64'd12 * (m % n)) / n);
      return (e > 58118000) ? 58118000 : e;
    endfunction

    // Note one accepted point; on the last point queue the expected result
    function void note_point(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] pz, logic last);
      longint x, y, a, d, xn, yn, ang;
      longint unsigned ua, ud, mx, ssum, r, maj, mnr;
      int s;
      res_t e;
      x = px; y = py;
      if (weighted) begin
        x = (x * pz) >>> 6;
        y = (y * pz) >>> 6;
      end
      if (cnt >= MAX_POINTS) begin
        ovf = 1;
      end else begin
        cnt++;
        sx += x; sy += y; sxx += x * x; sxy += x * y; syy += y * y;
      end
      if (!last) return;
      e = '0;
      if (cnt != 0) begin
        a = 2 * sxy;
        d = longint'(sxx) - longint'(syy);
        ua = (a < 0) ? -a : a;
        ud = (d < 0) ? -d : d;
        mx = (ua > ud) ? ua : ud;
        ssum = sxx + syy;
        s = 0;
        while ((mx >> s) >= (64'd1 << 30)) s++;
        ua >>= s;
        ud >>= s;
        xn = (d < 0) ? -longint'(ud) : longint'(ud);
        yn = (a < 0) ? -longint'(ua) : longint'(ua);
        ang = angle_q16(xn, yn);
        e.orient = ORIENT_W'((ang + (longint'(1) << (16 - ANGLE_FRAC_BITS)))
                             >>> (17 - ANGLE_FRAC_BITS));
        r = isqrt(ud * ud + ua * ua) << s;
        maj = (ssum + r) >> 1;
        mnr = (r > ssum) ? 0 : (ssum - r) >> 1;
        e.ext_major = EXT_W'(extent(maj, cnt));
        e.ext_minor = EXT_W'(extent(mnr, cnt));
      end
      e.count    = CNT_W'(cnt);
      e.sx       = SUM1_W'(sx);
      e.sy       = SUM1_W'(sy);
      e.sxx      = SUM2_W'(sxx);
      e.sxy      = SUMXY_W'(sxy);
      e.syy      = SUM2_W'(syy);
      e.empty    = (cnt == 0);
      e.overflow = ovf;
      results_due.insert(results_due.size(), e);
      clear_sums();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // Compare one result transfer with the oldest expectation
    task check_result(logic [351:0] d, logic [1:0] u);
      res_t e;
      if (results_due.size() == 0) begin
        report("unexpected result", d[63:0], 0);
        return;
      end
      e = results_due.pop_front();
      if (d[12:0]    != e.count)     report("point_count", d[12:0], e.count);
      if (d[53:13]   != e.sx)        report("sum_x", d[53:13], e.sx);
      if (d[94:54]   != e.sy)        report("sum_y", d[94:54], e.sy);
      if (d[155:95]  != e.sxx)       report("sum_xx", d[155:95], e.sxx);
      if (d[217:156] != e.sxy)       report("sum_xy", d[217:156], e.sxy);
      if (d[278:218] != e.syy)       report("sum_yy", d[278:218], e.syy);
      if (d[293:279] != e.orient)    report("orientation", d[293:279], e.orient);
      if (d[319:294] != e.ext_major) report("extent_major", d[319:294], e.ext_major);
      if (d[345:320] != e.ext_minor) report("extent_minor", d[345:320], e.ext_minor);
      if (u[0] != e.empty)           report("empty_cloud", u[0], e.empty);
      if (u[1] != e.overflow)        report("count_overflow", u[1], e.overflow);
    endtask
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_wr_en = 0;
  logic         cfg_wr_data = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [351:0] out_tdata;
  logic [1:0]   out_tuser;

  cloud_scoreboard moments = new();
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cycles = 0;

  point_moments_orientation_extent_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) moments.check_result(out_tdata, out_tuser);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one point and hold it until its transfer; valid stays up for the next one
  task send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {z, y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    moments.note_point(x, y, z, last);
  endtask

  // Drop valid, then hold until every result is in and the sequencer has settled
  task wait_idle();
    in_tvalid <= 0;
    while (moments.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_weighting(bit w);
    wait_idle();
    cfg_wr_en   <= 1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 0;
    moments.weighted = w;
  endtask

  function logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      default: return ($urandom_range(1)) ? 16'(16'h8000 + $urandom_range(15))
                                          : 16'(16'h7fff - $urandom_range(15));
    endcase
  endfunction

  // One random cloud, mostly small, with a value style shared by x and y
  task send_cloud(int npts);
    int mode;
    logic [15:0] x, y;
    mode = $urandom_range(2);
    for (int i = 0; i < npts; i++) begin
      x = rand_coord(mode);
      y = rand_coord(mode);
      case ($urandom_range(5))
        0: y = 0;
        1: x = 0;
        2: y = x;
        3: y = -x;
        default: ;
      endcase
      send_point(x, y, rand_coord($urandom_range(2)), i == npts - 1);
    end
  endtask

  initial begin
    int sent;
    moments.clear_sums();
    moments.weighted = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes and degenerate angles, plain weighting
    write_weighting(0);
    send_point(16'h8000, 16'h8000, 16'h0000, 1);
    send_point(16'h7fff, 16'h8000, 16'h7fff, 1);
    send_point(16'h0000, 16'h0000, 16'h0000, 1);
    send_point(16'h0005, 16'h0000, 16'h0001, 1);
    send_point(16'h0000, 16'h0005, 16'h0001, 0);
    send_point(16'h0000, 16'hfffb, 16'h0001, 1);
    send_point(16'h7fff, 16'h7fff, 16'h8000, 0);
    send_point(16'h8000, 16'h8000, 16'h7fff, 1);
    send_point(16'h0003, 16'hfffd, 16'h0000, 0);
    send_point(16'hfffd, 16'h0003, 16'h0000, 1);

    // Directed: height weighting at the extremes
    write_weighting(1);
    send_point(16'h8000, 16'h7fff, 16'h8000, 1);
    send_point(16'h0040, 16'hffc0, 16'hffff, 1);
    send_point(16'h1234, 16'h0000, 16'h0000, 1);
    send_point(16'h8000, 16'h8000, 16'h8000, 1);

    // Random clouds over idle patterns and both weightings
    for (int ph = 0; ph < 6; ph++) begin
      write_weighting(ph[0]);
      send_idle_pct = (ph / 2 == 0) ? 11 : (ph / 2 == 1) ? 83 : 0;
      recv_idle_pct = (ph / 2 == 0) ? 83 : (ph / 2 == 1) ? 11 : 0;
      sent = 0;
      while (sent < 320) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 8);
        send_cloud(n);
        sent += n;
      end
    end

    wait_idle();
    if (moments.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
